@@ hw/rtl/tbs_pkg.sv @@
// shared types and constants for the token bucket shaper
package tbs_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CAPACITY_RESET = 8'd10;

   // item kinds
   localparam logic KIND_TICK   = 1'b0;
   localparam logic KIND_PACKET = 1'b1;

   // drop causes
   localparam logic CAUSE_OVER_CAPACITY = 1'b0;
   localparam logic CAUSE_QUEUE_FULL    = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [15:0] packet_id;
      logic [7:0]  tokens_needed;
   } tbs_req_item_type;

   typedef struct packed {
      logic        token_dropped;
      logic        packet_dropped;
      logic        drop_cause;
      logic        release_valid;
      logic [15:0] release_id;
      logic [7:0]  release_tokens;
      logic [7:0]  bucket_level;
      logic [4:0]  queue_count;
   } tbs_rsp_item_type;

endpackage

@@ hw/rtl/token_bucket_shaper.sv @@
// token bucket shaper with waiting queue, top level
//
//   port group   dir   handshake            payload
//   req_         in    req_valid/req_ready  tbs_req_item_type
//   rsp_         out   rsp_valid/rsp_ready  tbs_rsp_item_type
//   csr_         in    csr_we               csr_wdata, bucket capacity
//
// one item per cycle while no result waits or rsp_ready is high; each result appears the cycle after its transfer
// bucket update, queue push/pop and drop decision are one compare-and-add step
// the result register frees in the same cycle it is taken, so req_ready follows
// rsp_ready while a result waits
// reset clears bucket, queue pointers and result valid; capacity returns to 10
module token_bucket_shaper (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tbs_pkg::tbs_req_item_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output tbs_pkg::tbs_rsp_item_type rsp_data,
   input  logic                     csr_we,
   input  logic [7:0]               csr_wdata
);
   import tbs_pkg::*;

   logic [7:0]        capacity_ff;
   logic [7:0]        level_ff, level_in;
   logic [QPTR_W-1:0] head_ff, head_in;
   logic [QPTR_W-1:0] tail_ff, tail_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              rsp_valid_ff;
   tbs_rsp_item_type  rsp_data_ff, rsp_in;

   logic [15:0]       queue_id  [QUEUE_DEPTH];
   logic [7:0]        queue_need[QUEUE_DEPTH];

   logic              req_fire;
   logic              push;
   logic [8:0]        level_inc;
   logic [7:0]        level_tick;
   logic [7:0]        head_need;

   function automatic logic [QPTR_W-1:0] next_slot(input logic [QPTR_W-1:0] idx);
      logic [QPTR_W-1:0] res;
      if (idx == QPTR_W'(QUEUE_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = idx + QPTR_W'(1);
      end
      return res;
   endfunction

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign head_need = queue_need[head_ff];
   assign level_inc = {1'b0, level_ff} + 9'd1;

   always_comb begin
      level_in   = level_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      push       = 1'b0;
      level_tick = level_ff;
      rsp_in     = '0;

      if (req_fire) begin
         if (req_data.req_type == KIND_TICK) begin
            if (level_inc > {1'b0, capacity_ff}) begin
               rsp_in.token_dropped = 1'b1;
            end else begin
               level_tick = level_inc[7:0];
            end
            level_in = level_tick;
            // at most one queued packet leaves per tick
            if (count_ff != '0 && head_need <= level_tick) begin
               rsp_in.release_valid  = 1'b1;
               rsp_in.release_id     = queue_id[head_ff];
               rsp_in.release_tokens = head_need;
               level_in              = level_tick - head_need;
               head_in               = next_slot(head_ff);
               count_in              = count_ff - QCNT_W'(1);
            end
         end else begin
            if (req_data.tokens_needed > capacity_ff) begin
               rsp_in.packet_dropped = 1'b1;
               rsp_in.drop_cause     = CAUSE_OVER_CAPACITY;
            end else if (count_ff == '0 && req_data.tokens_needed <= level_ff) begin
               rsp_in.release_valid  = 1'b1;
               rsp_in.release_id     = req_data.packet_id;
               rsp_in.release_tokens = req_data.tokens_needed;
               level_in              = level_ff - req_data.tokens_needed;
            end else if (count_ff == QCNT_W'(QUEUE_DEPTH)) begin
               rsp_in.packet_dropped = 1'b1;
               rsp_in.drop_cause     = CAUSE_QUEUE_FULL;
            end else begin
               push     = 1'b1;
               tail_in  = next_slot(tail_ff);
               count_in = count_ff + QCNT_W'(1);
            end
         end
      end

      rsp_in.bucket_level = level_in;
      rsp_in.queue_count  = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         level_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            capacity_ff <= csr_wdata;
         end
         level_ff <= level_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // queue entries need no reset: only written slots are ever read
   always_ff @(posedge clock) begin
      if (push) begin
         queue_id[tail_ff]   <= req_data.packet_id;
         queue_need[tail_ff] <= req_data.tokens_needed;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("no result after transfer");

   a_release_or_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.release_valid && rsp_data_ff.packet_dropped))
      else $error("packet both released and dropped");

   a_tick_pops_one: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.req_type == KIND_TICK |=>
         count_ff == $past(count_ff) || count_ff == $past(count_ff) - QCNT_W'(1))
      else $error("tick changed queue count by more than one");

   a_packet_no_pop: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.req_type == KIND_PACKET |=> count_ff >= $past(count_ff))
      else $error("packet arrival shrank the queue");

endmodule

@@ tb/tb_token_bucket_shaper.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the token bucket shaper
module tb_token_bucket_shaper;
   import tbs_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   tbs_req_item_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   tbs_rsp_item_type rsp_data;
   logic             csr_we;
   logic [7:0]       csr_wdata;

   // shaper state as the testbench sees it
   logic [7:0]       bucket_cap;
   int unsigned      bucket_tokens;
   logic [15:0]      held_ids[$];
   logic [7:0]       held_needs[$];
   tbs_rsp_item_type due_results[$];

   int               errors = 0;
   int               cycle_count = 0;
   int               hold_cycles = 0;
   rx_mode_type      rx_mode = RX_ALWAYS;
   logic [7:0]       rx_pattern = 8'hFF;

   token_bucket_shaper dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // one step of the bucket and its waiting queue
   function automatic tbs_rsp_item_type shape_step(input tbs_req_item_type it);
      tbs_rsp_item_type r;
      r = '0;
      if (it.req_type == KIND_TICK) begin
         if (bucket_tokens + 1 > bucket_cap) begin
            r.token_dropped = 1'b1;
         end else begin
            bucket_tokens++;
         end
         if (held_needs.size() > 0 && held_needs[0] <= bucket_tokens) begin
            r.release_valid  = 1'b1;
            r.release_id     = held_ids[0];
            r.release_tokens = held_needs[0];
            bucket_tokens    -= held_needs[0];
            void'(held_ids.pop_front());
            void'(held_needs.pop_front());
         end
      end else if (it.tokens_needed > bucket_cap) begin
         r.packet_dropped = 1'b1;
         r.drop_cause     = CAUSE_OVER_CAPACITY;
      end else if (held_needs.size() == 0 && it.tokens_needed <= bucket_tokens) begin
         r.release_valid  = 1'b1;
         r.release_id     = it.packet_id;
         r.release_tokens = it.tokens_needed;
         bucket_tokens    -= it.tokens_needed;
      end else if (held_needs.size() >= QUEUE_DEPTH) begin
         r.packet_dropped = 1'b1;
         r.drop_cause     = CAUSE_QUEUE_FULL;
      end else begin
         held_ids.push_back(it.packet_id);
         held_needs.push_back(it.tokens_needed);
      end
      r.bucket_level = 8'(bucket_tokens);
      r.queue_count  = 5'(held_needs.size());
      return r;
   endfunction

   // valid stays high after the transfer; the caller either sends again or pauses
   task automatic send_item(input tbs_req_item_type it);
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      due_results.push_back(shape_step(it));
   endtask

   task automatic send_tick();
      tbs_req_item_type it;
      it.req_type      = KIND_TICK;
      it.packet_id     = 16'($urandom);
      it.tokens_needed = 8'($urandom);
      send_item(it);
   endtask

   task automatic send_packet(input logic [15:0] id, input logic [7:0] need);
      tbs_req_item_type it;
      it.req_type      = KIND_PACKET;
      it.packet_id     = id;
      it.tokens_needed = need;
      send_item(it);
   endtask

   task automatic pause_req(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // capacity changes only once every result is out
   task automatic write_capacity(input logic [7:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we     <= 1'b0;
      bucket_cap = value;
   endtask

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : check_results
      tbs_rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            $error("result transfer with no expectation waiting");
            errors++;
         end else begin
            want = due_results.pop_front();
            check_field("token_dropped", want.token_dropped, rsp_data.token_dropped);
            check_field("packet_dropped", want.packet_dropped, rsp_data.packet_dropped);
            check_field("drop_cause", want.drop_cause, rsp_data.drop_cause);
            check_field("release_valid", want.release_valid, rsp_data.release_valid);
            check_field("release_id", want.release_id, rsp_data.release_id);
            check_field("release_tokens", want.release_tokens, rsp_data.release_tokens);
            check_field("bucket_level", want.bucket_level, rsp_data.bucket_level);
            check_field("queue_count", want.queue_count, rsp_data.queue_count);
         end
      end
   end

   // result side: a requested hold-off wins over the current stall pattern
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else begin
            case (rx_mode)
               RX_ALWAYS: rsp_ready <= 1'b1;
               RX_RANDOM: rsp_ready <= ($urandom_range(0, 9) < 6);
               default: begin
                  rsp_ready  <= rx_pattern[0];
                  rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
               end
            endcase
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   task automatic test_reset_capacity();
      send_packet(16'h0000, 8'd0);
      send_packet(16'hFFFF, 8'd11);
      send_packet(16'h8000, 8'hFF);
   endtask

   task automatic test_zero_capacity();
      write_capacity(8'd0);
      send_tick();
      send_packet(16'h0001, 8'd0);
   endtask

   task automatic test_token_overflow();
      write_capacity(8'd2);
      repeat (3) send_tick();
      send_packet(16'hFFFF, 8'd2);
   endtask

   // a packet behind a non-empty queue waits even when the bucket holds enough tokens for it
   task automatic test_queue_order();
      write_capacity(8'd255);
      send_packet(16'h00AA, 8'd1);
      send_packet(16'h0055, 8'd0);
      repeat (2) send_tick();
   endtask

   task automatic test_blocked_head();
      write_capacity(8'd3);
      send_packet(16'h1234, 8'd3);
      write_capacity(8'd2);
      repeat (2) send_tick();
      write_capacity(8'd3);
      send_tick();
   endtask

   task automatic test_level_above_capacity();
      write_capacity(8'd4);
      repeat (3) send_tick();
      write_capacity(8'd1);
      send_tick();
      send_packet(16'h7FFF, 8'd1);
   endtask

   // long receiver hold-off while the sender keeps offering; the packet-heavy mix can fill the queue to full drops
   task automatic test_backpressure();
      write_capacity(8'd6);
      rx_mode     = RX_ALWAYS;
      hold_cycles = 80;
      repeat (40) begin
         if ($urandom_range(0, 3) == 0) send_tick();
         else send_packet(16'($urandom), 8'($urandom_range(1, 6)));
      end
   endtask

   task automatic test_random_traffic();
      int phase;
      int left;
      int burst;
      int tick_pct;
      bit gaps;
      logic [7:0] cap;
      for (phase = 0; phase < 10; phase++) begin
         case ($urandom_range(0, 5))
            0: cap = 8'd255;
            1: cap = 8'd1;
            2, 3: cap = 8'($urandom_range(1, 16));
            4: cap = 8'($urandom_range(17, 64));
            default: cap = 8'($urandom_range(1, 255));
         endcase
         write_capacity(cap);
         tick_pct   = $urandom_range(15, 85);
         gaps       = ($urandom_range(0, 3) != 0);
         rx_mode    = rx_mode_type'($urandom_range(0, 2));
         rx_pattern = 8'($urandom) | 8'h01;
         left       = 100;
         while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left) burst = left;
            repeat (burst) begin
               if ($urandom_range(0, 99) < tick_pct) send_tick();
               else if ($urandom_range(0, 99) < 85)
                  send_packet(16'($urandom), 8'($urandom_range(0, cap)));
               else send_packet(16'($urandom), 8'($urandom));
            end
            left -= burst;
            if (gaps) pause_req($urandom_range(1, 6));
         end
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data      <= '0;
      csr_we        <= 1'b0;
      csr_wdata     <= '0;
      bucket_cap    = CAPACITY_RESET;
      bucket_tokens = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_capacity();
      test_zero_capacity();
      test_token_overflow();
      test_queue_order();
      test_blocked_head();
      test_level_above_capacity();
      test_backpressure();
      test_random_traffic();

      pause_req(1);
      while (due_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/tbs_pkg.sv
hw/rtl/token_bucket_shaper.sv
tb/tb_token_bucket_shaper.sv
